// ----- rtl/core/stereo_resample_ring_mixer_macros.svh -----
// Assertion macros for the stereo resample ring mixer.
// Used by the top level; expands to nothing when SYNTHESIS is defined.
`ifndef STEREO_RESAMPLE_RING_MIXER_MACROS_SVH
`define STEREO_RESAMPLE_RING_MIXER_MACROS_SVH
`ifndef SYNTHESIS
`define SRRM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("srrm: assertion failed");
`define SRRM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("srrm: assertion failed");
`else
`define SRRM_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SRRM_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- rtl/core/srrm_pkg.sv -----
// Shared types, constants and helpers for the stereo resample ring mixer.
// No dependencies.
`default_nettype none
package srrm_pkg;

  localparam int RING_SAMPLES = 65536;
  localparam int RING_AW      = $clog2(RING_SAMPLES);
  localparam int LVL_XW       = (RING_AW > 16) ? RING_AW : 16;

  localparam int STEP_W  = 17;
  localparam int PHASE_W = 19;
  localparam int VOL_W   = 16;
  localparam int SMP_W   = 16;
  localparam int PROD_W  = 49;
  localparam int SUM_W   = 50;

  localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(65536);
  localparam logic [STEP_W-1:0]  MIN_STEP  = STEP_W'(23777);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [STEP_W-1:0] RATE_STEP_RST    = STEP_W'(65536);
  localparam logic              STEREO_RST       = 1'b1;
  localparam logic [VOL_W-1:0]  MUSIC_VOLUME_RST = VOL_W'(32768);
  localparam logic              PAUSED_RST       = 1'b0;

  localparam int FULL_MIN_INT = (RING_SAMPLES - 6 > 65535) ? 65535 : RING_SAMPLES - 6;
  localparam logic [15:0] FULL_LEVEL_MIN = 16'(FULL_MIN_INT);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RATE_STEP    = 2'd0,
    CFG_STEREO       = 2'd1,
    CFG_MUSIC_VOLUME = 2'd2,
    CFG_PAUSED       = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    FUNC_PUSH  = 2'd0,
    FUNC_MIX   = 2'd1,
    FUNC_START = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_PAUSED = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEC,
    S_CNT,
    S_CHK,
    S_WR,
    S_MUL,
    S_SUM,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]              func;
    logic signed [SMP_W-1:0] left_sample;
    logic signed [SMP_W-1:0] right_sample;
    logic signed [SMP_W-1:0] mix_in;
    logic [VOL_W-1:0]        system_volume;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [SMP_W-1:0] mixed_sample;
    logic [15:0]             ring_level;
  } out_item_t;

  typedef struct packed {
    logic    latch;
    logic    cnt_step;
    logic    wr;
    logic    commit;
    logic    rd;
    logic    mul;
    logic    sum;
    logic    clear;
    logic    set_status;
    status_e status_code;
    logic    emit;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       paused;
    logic       empty;
    logic       acc_below;
    logic       fits;
    logic       pairs_zero;
    logic       wr_last;
  } stat_t;

  function automatic logic [15:0] sat_level(input logic [RING_AW-1:0] lvl);
    logic [LVL_XW-1:0] w;
    w = LVL_XW'(lvl);
    if (w > LVL_XW'(16'hFFFF)) begin
      return 16'hFFFF;
    end
    return w[15:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/srrm_ctrl.sv -----
// Controller state machine for the stereo resample ring mixer.
// Depends on srrm_pkg; drives the datapath srrm_dp through cmd_t.
`default_nettype none
module srrm_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  input  wire srrm_pkg::stat_t stat_i,
  output srrm_pkg::cmd_t      cmd_o
);

  srrm_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic emit_ok;

  assign emit_ok = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= srrm_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      srrm_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = srrm_pkg::S_DEC;
        end
      end
      srrm_pkg::S_DEC: begin
        case (stat_i.func)
          srrm_pkg::FUNC_PUSH: state_d = srrm_pkg::S_CNT;
          srrm_pkg::FUNC_MIX: begin
            if (stat_i.paused || stat_i.empty) begin
              state_d = srrm_pkg::S_DONE;
            end else begin
              state_d = srrm_pkg::S_MUL;
            end
          end
          default: state_d = srrm_pkg::S_DONE;
        endcase
      end
      srrm_pkg::S_CNT: begin
        if (!stat_i.acc_below) begin
          state_d = srrm_pkg::S_CHK;
        end
      end
      srrm_pkg::S_CHK: begin
        if (stat_i.fits && !stat_i.pairs_zero) begin
          state_d = srrm_pkg::S_WR;
        end else begin
          state_d = srrm_pkg::S_DONE;
        end
      end
      srrm_pkg::S_WR: begin
        if (stat_i.wr_last) begin
          state_d = srrm_pkg::S_DONE;
        end
      end
      srrm_pkg::S_MUL: state_d = srrm_pkg::S_SUM;
      srrm_pkg::S_SUM: state_d = srrm_pkg::S_DONE;
      srrm_pkg::S_DONE: begin
        if (emit_ok) begin
          state_d = srrm_pkg::S_IDLE;
        end
      end
      default: state_d = srrm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o             = '0;
    cmd_o.status_code = srrm_pkg::ST_DONE;
    unique case (state_q)
      srrm_pkg::S_IDLE: cmd_o.latch = in_valid_i;
      srrm_pkg::S_DEC: begin
        case (stat_i.func)
          srrm_pkg::FUNC_MIX: begin
            if (stat_i.paused) begin
              cmd_o.set_status  = 1'b1;
              cmd_o.status_code = srrm_pkg::ST_PAUSED;
            end else if (stat_i.empty) begin
              cmd_o.set_status  = 1'b1;
              cmd_o.status_code = srrm_pkg::ST_EMPTY;
            end else begin
              cmd_o.rd = 1'b1;
            end
          end
          srrm_pkg::FUNC_START: cmd_o.clear = 1'b1;
          default: ;
        endcase
      end
      srrm_pkg::S_CNT: cmd_o.cnt_step = stat_i.acc_below;
      srrm_pkg::S_CHK: begin
        if (!stat_i.fits) begin
          cmd_o.set_status  = 1'b1;
          cmd_o.status_code = srrm_pkg::ST_FULL;
        end else if (stat_i.pairs_zero) begin
          cmd_o.commit = 1'b1;
        end
      end
      srrm_pkg::S_WR: begin
        cmd_o.wr     = 1'b1;
        cmd_o.commit = stat_i.wr_last;
      end
      srrm_pkg::S_MUL: cmd_o.mul = 1'b1;
      srrm_pkg::S_SUM: cmd_o.sum = 1'b1;
      srrm_pkg::S_DONE: cmd_o.emit = emit_ok;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign in_stall_o  = (state_q != srrm_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ----- rtl/core/srrm_dp.sv -----
// Datapath for the stereo resample ring mixer: registers, sample ring, scaler.
// Depends on srrm_pkg; commanded by srrm_ctrl through cmd_t.
`default_nettype none
module srrm_dp (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire srrm_pkg::in_item_t                  in_data_i,
  input  wire logic                                cfg_we_i,
  input  wire logic [srrm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [srrm_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire srrm_pkg::cmd_t                      cmd_i,
  output srrm_pkg::stat_t                          stat_o,
  output srrm_pkg::out_item_t                      out_data_o
);

  logic [srrm_pkg::SMP_W-1:0] ring_mem [srrm_pkg::RING_SAMPLES];

  logic [srrm_pkg::STEP_W-1:0]  rate_step_q;
  logic                         stereo_q;
  logic [srrm_pkg::VOL_W-1:0]   music_vol_q;
  logic                         paused_q;

  logic [srrm_pkg::RING_AW-1:0] wr_idx_q, rd_idx_q, level_q;
  logic [srrm_pkg::PHASE_W-1:0] phase_q, acc_q;
  logic [1:0]                   pairs_q;
  logic                         half_q;
  logic [1:0]                   status_q;
  logic signed [srrm_pkg::SMP_W-1:0] mixed_q;

  srrm_pkg::in_item_t               item_q;
  logic [2*srrm_pkg::VOL_W-1:0]      vol_q;
  logic signed [srrm_pkg::SMP_W-1:0] rd_data_q;
  logic signed [srrm_pkg::PROD_W-1:0] prod_q;
  srrm_pkg::out_item_t              out_q;

  logic [srrm_pkg::STEP_W-1:0]  step_eff;
  logic [srrm_pkg::RING_AW:0]   need;
  logic [srrm_pkg::SMP_W-1:0]   wr_sample;
  logic [srrm_pkg::RING_AW-1:0] wr_idx_nxt, rd_idx_nxt;
  logic signed [srrm_pkg::PROD_W:0]   prod_s;
  logic signed [srrm_pkg::SUM_W-1:0]  rnd;
  logic signed [srrm_pkg::SUM_W-31:0] q_s;
  logic signed [srrm_pkg::SUM_W-29:0] mix_sum;
  logic signed [srrm_pkg::SMP_W-1:0]  mix_sat;
  logic signed [srrm_pkg::VOL_W*2:0]  vol_s;

  localparam logic [srrm_pkg::RING_AW-1:0] IDX_LAST = srrm_pkg::RING_AW'(srrm_pkg::RING_SAMPLES - 1);

  assign step_eff   = (rate_step_q < srrm_pkg::MIN_STEP) ? srrm_pkg::MIN_STEP : rate_step_q;
  assign need       = (srrm_pkg::RING_AW + 1)'(level_q)
                    + (srrm_pkg::RING_AW + 1)'({pairs_q, 1'b0});
  assign wr_sample  = (half_q && stereo_q) ? item_q.right_sample : item_q.left_sample;
  assign wr_idx_nxt = (wr_idx_q == IDX_LAST) ? '0 : wr_idx_q + 1'b1;
  assign rd_idx_nxt = (rd_idx_q == IDX_LAST) ? '0 : rd_idx_q + 1'b1;
  assign vol_s      = $signed({1'b0, vol_q});

  always_comb begin
    prod_s  = {prod_q[srrm_pkg::PROD_W-1], prod_q};
    rnd     = srrm_pkg::SUM_W'(prod_s) + (srrm_pkg::SUM_W'(1) <<< 29);
    q_s     = rnd[srrm_pkg::SUM_W-1:30];
    mix_sum = (srrm_pkg::SUM_W-28)'(item_q.mix_in) + (srrm_pkg::SUM_W-28)'(q_s);
    if (mix_sum > 22'sd32767) begin
      mix_sat = 16'sh7FFF;
    end else if (mix_sum < -22'sd32768) begin
      mix_sat = 16'sh8000;
    end else begin
      mix_sat = mix_sum[srrm_pkg::SMP_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_step_q <= srrm_pkg::RATE_STEP_RST;
      stereo_q    <= srrm_pkg::STEREO_RST;
      music_vol_q <= srrm_pkg::MUSIC_VOLUME_RST;
      paused_q    <= srrm_pkg::PAUSED_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        srrm_pkg::CFG_RATE_STEP:    rate_step_q <= cfg_data_i[srrm_pkg::STEP_W-1:0];
        srrm_pkg::CFG_STEREO:       stereo_q    <= cfg_data_i[0];
        srrm_pkg::CFG_MUSIC_VOLUME: music_vol_q <= cfg_data_i[srrm_pkg::VOL_W-1:0];
        srrm_pkg::CFG_PAUSED:       paused_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q <= '0;
      rd_idx_q <= '0;
      level_q  <= '0;
      phase_q  <= '0;
    end else begin
      if (cmd_i.clear) begin
        wr_idx_q <= '0;
        rd_idx_q <= '0;
        level_q  <= '0;
        phase_q  <= '0;
      end
      if (cmd_i.wr) begin
        wr_idx_q <= wr_idx_nxt;
        level_q  <= level_q + 1'b1;
      end
      if (cmd_i.rd) begin
        rd_idx_q <= rd_idx_nxt;
        level_q  <= level_q - 1'b1;
      end
      if (cmd_i.commit) begin
        phase_q <= acc_q - srrm_pkg::PHASE_ONE;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      item_q   <= in_data_i;
      acc_q    <= phase_q;
      pairs_q  <= '0;
      half_q   <= 1'b0;
      mixed_q  <= in_data_i.mix_in;
      status_q <= srrm_pkg::ST_DONE;
    end
    if (cmd_i.cnt_step) begin
      acc_q   <= acc_q + srrm_pkg::PHASE_W'(step_eff);
      pairs_q <= pairs_q + 1'b1;
    end
    if (cmd_i.wr) begin
      half_q <= !half_q;
      if (half_q) begin
        pairs_q <= pairs_q - 1'b1;
      end
    end
    if (cmd_i.rd) begin
      vol_q <= item_q.system_volume * music_vol_q;
    end
    if (cmd_i.mul) begin
      prod_q <= rd_data_q * vol_s;
    end
    if (cmd_i.sum) begin
      mixed_q <= mix_sat;
    end
    if (cmd_i.set_status) begin
      status_q <= cmd_i.status_code;
    end
    if (cmd_i.emit) begin
      out_q.status       <= status_q;
      out_q.mixed_sample <= mixed_q;
      out_q.ring_level   <= srrm_pkg::sat_level(level_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      ring_mem[wr_idx_q] <= wr_sample;
    end
    if (cmd_i.rd) begin
      rd_data_q <= ring_mem[rd_idx_q];
    end
  end

  assign stat_o.func       = item_q.func;
  assign stat_o.paused     = paused_q;
  assign stat_o.empty      = (level_q == '0);
  assign stat_o.acc_below  = (acc_q < srrm_pkg::PHASE_ONE);
  assign stat_o.fits       = (need < (srrm_pkg::RING_AW + 1)'(srrm_pkg::RING_SAMPLES));
  assign stat_o.pairs_zero = (pairs_q == 2'd0);
  assign stat_o.wr_last    = half_q && (pairs_q == 2'd1);

  assign out_data_o = out_q;

endmodule
`default_nettype wire

// ----- rtl/core/stereo_resample_ring_mixer.sv -----
// Top level of the stereo resample ring mixer: controller plus datapath.
// Depends on srrm_pkg, srrm_ctrl, srrm_dp and the assertion macro header.
//
// Input channel (in_valid_i / in_stall_o / in_data_i): one beat per item.
// A push writes the frame into the sample ring as zero to three stereo pairs
// by nearest-neighbor resampling, or refuses it whole when the ring lacks room.
// A mix pops one sample, scales it by both volumes and adds it to mix_in with
// saturation. A start clears the ring pointers, the level and the phase.
// Output channel (out_valid_o / out_stall_i / out_data_o): one result beat
// per item, held in an output register until taken.
// Config channel (cfg_valid_i / cfg_ready_o): always ready; write only while
// no item is in flight.
// Steps: an accepted push runs the phase step loop, a room check and then the
// writes through the single ring write port; a refused push stops after the
// check. A mix does a ring read, two multiplies, round and add, and when paused
// or empty only sets that status; start and unused codes go from decode to the
// result. The next item is accepted while a result still waits; a stalled
// receiver holds the block only once a second result is ready.
// Reset clears pointers, level and phase and loads register defaults; ring
// contents are left as they are.
`default_nettype none
`include "stereo_resample_ring_mixer_macros.svh"
module stereo_resample_ring_mixer (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire srrm_pkg::in_item_t              in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output srrm_pkg::out_item_t                  out_data_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [srrm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [srrm_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  srrm_pkg::cmd_t  cmd;
  srrm_pkg::stat_t stat;
  logic            out_empty_beat;
  logic            out_full_beat;
  logic            full_level_ok;

  assign cfg_ready_o = 1'b1;

  srrm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  srrm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_data_o  (out_data_o)
  );

  assign out_empty_beat = out_valid_o && (out_data_o.status == srrm_pkg::ST_EMPTY);
  assign out_full_beat  = out_valid_o && (out_data_o.status == srrm_pkg::ST_FULL);
  assign full_level_ok  = (out_data_o.ring_level >= srrm_pkg::FULL_LEVEL_MIN);

  `SRRM_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `SRRM_ASSERT_IMP(a_empty_level_zero, clk_i, rst_ni, out_empty_beat, out_data_o.ring_level == 16'd0)
  `SRRM_ASSERT_IMP(a_full_level_high, clk_i, rst_ni, out_full_beat, full_level_ok)

endmodule
`default_nettype wire
